@@ rtl/tibc_pkg.sv @@
package tibc_pkg;

   localparam int STATE_W = 3;
   localparam int TICK_W  = 8;

   localparam logic [STATE_W-1:0] ST_INIT    = 3'd0;
   localparam logic [STATE_W-1:0] ST_OFF     = 3'd1;
   localparam logic [STATE_W-1:0] ST_ACT_ON  = 3'd2;
   localparam logic [STATE_W-1:0] ST_ACT_OFF = 3'd3;
   localparam logic [STATE_W-1:0] ST_ACK_ON  = 3'd4;
   localparam logic [STATE_W-1:0] ST_ACK_OFF = 3'd5;
   localparam logic [STATE_W-1:0] ST_FAULT   = 3'd6;
   localparam logic [STATE_W-1:0] ST_HALTED  = 3'd7;

   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd10;

   typedef struct packed {
      logic hazard_cmd;
      logic left_cmd;
      logic right_cmd;
      logic ack_left;
      logic ack_right;
   } req_type;

   typedef struct packed {
      logic               lamp_hazard;
      logic               lamp_left;
      logic               lamp_right;
      logic               clear_ack_left;
      logic               clear_ack_right;
      logic [STATE_W-1:0] state_code;
      logic               halted;
   } rsp_type;

endpackage

@@ rtl/tibc_ifs.sv @@
interface tibc_req_if;
   logic valid;
   logic ready;
   logic hazard_cmd;
   logic left_cmd;
   logic right_cmd;
   logic ack_left;
   logic ack_right;

   modport source (output valid, output hazard_cmd, output left_cmd, output right_cmd,
                   output ack_left, output ack_right, input ready);
   modport sink (input valid, input hazard_cmd, input left_cmd, input right_cmd,
                 input ack_left, input ack_right, output ready);
endinterface

interface tibc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         lamp_hazard;
   logic                         lamp_left;
   logic                         lamp_right;
   logic                         clear_ack_left;
   logic                         clear_ack_right;
   logic [tibc_pkg::STATE_W-1:0] state_code;
   logic                         halted;

   modport source (output valid, output lamp_hazard, output lamp_left, output lamp_right,
                   output clear_ack_left, output clear_ack_right, output state_code,
                   output halted, input ready);
   modport sink (input valid, input lamp_hazard, input lamp_left, input lamp_right,
                 input clear_ack_left, input clear_ack_right, input state_code,
                 input halted, output ready);
endinterface

@@ rtl/turn_indicator_blink_controller.sv @@
// Turn indicator blink controller.
// The req channel carries one word per 100 ms tick: the hazard, left and right
// commands and the pending left and right acknowledge bits. The rsp channel
// returns one word per tick with the lamp flags, the acknowledge bits that were
// consumed, the controller state code and a halted flag.
// The csr port writes the 8-bit timeout in ticks; it resets to 10. It must be
// written only while no words are in flight: the user is bound to this, as the
// block itself does not enforce it. A word is taken into an input register, and
// the state update runs in one combinational pass into the result register; one
// word is taken every cycle while the receiver keeps rsp ready high.
// When the receiver holds rsp ready low, the result register holds its word, and
// the input register takes one more word only if it is empty, then req ready drops.
// Reset clears the valid bits of both registers, puts the controller in its init
// state with all lamps off and the tick counter clear, and reloads the timeout.
module turn_indicator_blink_controller (
   input  logic                        clock,
   input  logic                        reset,
   tibc_req_if.sink                    req,
   tibc_rsp_if.source                  rsp,
   input  logic                        csr_wr_en,
   input  logic [tibc_pkg::TICK_W-1:0] csr_wr_data
);

   logic                        in_valid_ff;
   tibc_pkg::req_type           in_data_ff;
   logic                        out_valid_ff;
   tibc_pkg::rsp_type           out_data_ff;
   logic [tibc_pkg::TICK_W-1:0] timeout_ff;
   logic                        advance;
   tibc_pkg::rsp_type           core_rsp;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= tibc_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_data_ff.hazard_cmd <= req.hazard_cmd;
         in_data_ff.left_cmd   <= req.left_cmd;
         in_data_ff.right_cmd  <= req.right_cmd;
         in_data_ff.ack_left   <= req.ack_left;
         in_data_ff.ack_right  <= req.ack_right;
      end
   end

   tibc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_word (in_data_ff),
      .timeout  (timeout_ff),
      .rsp_word (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.lamp_hazard     = out_data_ff.lamp_hazard;
   assign rsp.lamp_left       = out_data_ff.lamp_left;
   assign rsp.lamp_right      = out_data_ff.lamp_right;
   assign rsp.clear_ack_left  = out_data_ff.clear_ack_left;
   assign rsp.clear_ack_right = out_data_ff.clear_ack_right;
   assign rsp.state_code      = out_data_ff.state_code;
   assign rsp.halted          = out_data_ff.halted;

endmodule

@@ rtl/tibc_core.sv @@
module tibc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  tibc_pkg::req_type           req_word,
   input  logic [tibc_pkg::TICK_W-1:0] timeout,
   output tibc_pkg::rsp_type           rsp_word
);

   logic [tibc_pkg::STATE_W-1:0] state_ff, state_in;
   logic [tibc_pkg::TICK_W-1:0]  tick_ff, tick_in, tick_inc;
   logic                         hazard_ff, hazard_in;
   logic                         left_ff, left_in;
   logic                         right_ff, right_in;
   logic                         cmd_off;
   logic                         ack_l, ack_r;
   logic                         clr_l, clr_r;

   assign tick_inc = tick_ff + 8'd1;

   // A command that is low only counts as "off" if its lamp is currently lit.
   assign cmd_off = (!req_word.hazard_cmd && hazard_ff) ||
                    (!req_word.left_cmd && left_ff) ||
                    (!req_word.right_cmd && right_ff);

   // Hazard needs both acknowledges; each side lamp needs its own.
   assign ack_l = (req_word.hazard_cmd && req_word.ack_left && req_word.ack_right) ||
                  (req_word.left_cmd && req_word.ack_left);
   assign ack_r = (req_word.hazard_cmd && req_word.ack_left && req_word.ack_right) ||
                  (req_word.right_cmd && req_word.ack_right);

   always_comb begin
      state_in  = state_ff;
      tick_in   = tick_ff;
      hazard_in = hazard_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      clr_l     = 1'b0;
      clr_r     = 1'b0;
      case (state_ff)
         tibc_pkg::ST_INIT: begin
            hazard_in = 1'b0;
            left_in   = 1'b0;
            right_in  = 1'b0;
            tick_in   = '0;
            state_in  = tibc_pkg::ST_OFF;
         end
         tibc_pkg::ST_OFF: begin
            if (req_word.hazard_cmd || req_word.left_cmd || req_word.right_cmd) begin
               hazard_in = hazard_ff | req_word.hazard_cmd;
               left_in   = left_ff | req_word.left_cmd;
               right_in  = right_ff | req_word.right_cmd;
               state_in  = tibc_pkg::ST_ACT_ON;
            end
         end
         tibc_pkg::ST_ACT_ON, tibc_pkg::ST_ACT_OFF: begin
            tick_in = tick_inc;
            if (cmd_off) begin
               hazard_in = hazard_ff & req_word.hazard_cmd;
               left_in   = left_ff & req_word.left_cmd;
               right_in  = right_ff & req_word.right_cmd;
               tick_in   = '0;
               state_in  = tibc_pkg::ST_OFF;
            end else if (tick_inc >= timeout) begin
               tick_in  = '0;
               state_in = tibc_pkg::ST_FAULT;
            end else begin
               clr_l = ack_l;
               clr_r = ack_r;
               if (ack_l || ack_r) begin
                  state_in = (state_ff == tibc_pkg::ST_ACT_ON) ? tibc_pkg::ST_ACK_ON
                                                                : tibc_pkg::ST_ACK_OFF;
               end
            end
         end
         tibc_pkg::ST_ACK_ON, tibc_pkg::ST_ACK_OFF: begin
            tick_in = tick_inc;
            if (cmd_off) begin
               hazard_in = hazard_ff & req_word.hazard_cmd;
               left_in   = left_ff & req_word.left_cmd;
               right_in  = right_ff & req_word.right_cmd;
               tick_in   = '0;
               state_in  = tibc_pkg::ST_OFF;
            end else if (tick_inc >= timeout) begin
               hazard_in = hazard_ff ^ req_word.hazard_cmd;
               left_in   = left_ff ^ req_word.left_cmd;
               right_in  = right_ff ^ req_word.right_cmd;
               tick_in   = '0;
               state_in  = (state_ff == tibc_pkg::ST_ACK_ON) ? tibc_pkg::ST_ACT_OFF
                                                             : tibc_pkg::ST_ACT_ON;
            end
         end
         tibc_pkg::ST_FAULT: begin
            hazard_in = 1'b0;
            left_in   = 1'b0;
            right_in  = 1'b0;
            state_in  = tibc_pkg::ST_HALTED;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_comb begin
      rsp_word.lamp_hazard     = hazard_in;
      rsp_word.lamp_left       = left_in;
      rsp_word.lamp_right      = right_in;
      rsp_word.clear_ack_left  = clr_l;
      rsp_word.clear_ack_right = clr_r;
      rsp_word.state_code      = state_in;
      rsp_word.halted          = (state_in == tibc_pkg::ST_HALTED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tibc_pkg::ST_INIT;
         tick_ff   <= '0;
         hazard_ff <= 1'b0;
         left_ff   <= 1'b0;
         right_ff  <= 1'b0;
      end else if (step) begin
         state_ff  <= state_in;
         tick_ff   <= tick_in;
         hazard_ff <= hazard_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
      end
   end

   // Once halted, the controller never leaves that state.
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff == tibc_pkg::ST_HALTED |=> state_ff == tibc_pkg::ST_HALTED)
      else $error("controller left the halted state");

   // A halted controller keeps every lamp dark.
   a_halt_dark: assert property (@(posedge clock) disable iff (reset)
      state_ff == tibc_pkg::ST_HALTED |-> !(hazard_ff || left_ff || right_ff))
      else $error("lamp lit while halted");

   // The tick counter is always clear while waiting in the off state.
   a_off_tick_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == tibc_pkg::ST_OFF |-> tick_ff == '0)
      else $error("tick counter not clear in off state");

   // Acknowledges are consumed only in an activated state.
   a_ack_only_active: assert property (@(posedge clock) disable iff (reset)
      step && (clr_l || clr_r) |->
         (state_ff == tibc_pkg::ST_ACT_ON || state_ff == tibc_pkg::ST_ACT_OFF))
      else $error("acknowledge consumed outside an activated state");

endmodule

@@ tb/tb_turn_indicator_blink_controller.sv @@
module tb_turn_indicator_blink_controller;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int NUM_PHASES = 8;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [tibc_pkg::TICK_W-1:0] csr_wr_data;

   tibc_req_if req_ch ();
   tibc_rsp_if rsp_ch ();

   turn_indicator_blink_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Tracks the controller state and holds the lamp reports that are due.
   class blink_scoreboard;
      logic [tibc_pkg::TICK_W-1:0]  timeout;
      logic [tibc_pkg::STATE_W-1:0] state;
      logic [tibc_pkg::TICK_W-1:0]  ticks;
      logic                         hz_lit;
      logic                         left_lit;
      logic                         right_lit;
      tibc_pkg::rsp_type            due_reports[$];
      int                           mismatches;

      function new();
         timeout = tibc_pkg::TIMEOUT_RESET;
         state = tibc_pkg::ST_INIT;
         ticks = '0;
         hz_lit = 1'b0;
         left_lit = 1'b0;
         right_lit = 1'b0;
         mismatches = 0;
      endfunction

      function void set_timeout(logic [tibc_pkg::TICK_W-1:0] value);
         timeout = value;
      endfunction

      function int outstanding();
         return due_reports.size();
      endfunction

      // A lit lamp whose command has gone low counts as a switch-off.
      function bit switched_off(tibc_pkg::req_type w);
         return (!w.hazard_cmd && hz_lit) || (!w.left_cmd && left_lit) ||
                (!w.right_cmd && right_lit);
      endfunction

      function void go_dark(tibc_pkg::req_type w);
         if (!w.hazard_cmd) hz_lit = 1'b0;
         if (!w.left_cmd) left_lit = 1'b0;
         if (!w.right_cmd) right_lit = 1'b0;
         ticks = '0;
         state = tibc_pkg::ST_OFF;
      endfunction

      function void note_tick(tibc_pkg::req_type w);
         tibc_pkg::rsp_type r;
         r = '0;
         case (state)
            tibc_pkg::ST_INIT: begin
               hz_lit = 1'b0;
               left_lit = 1'b0;
               right_lit = 1'b0;
               ticks = '0;
               state = tibc_pkg::ST_OFF;
            end
            tibc_pkg::ST_OFF: begin
               if (w.hazard_cmd || w.left_cmd || w.right_cmd) begin
                  if (w.hazard_cmd) hz_lit = 1'b1;
                  if (w.left_cmd) left_lit = 1'b1;
                  if (w.right_cmd) right_lit = 1'b1;
                  state = tibc_pkg::ST_ACT_ON;
               end
            end
            tibc_pkg::ST_ACT_ON, tibc_pkg::ST_ACT_OFF: begin
               ticks = ticks + 8'd1;
               if (switched_off(w)) begin
                  go_dark(w);
               end else if (ticks >= timeout) begin
                  ticks = '0;
                  state = tibc_pkg::ST_FAULT;
               end else begin
                  if (w.hazard_cmd && w.ack_left && w.ack_right) begin
                     r.clear_ack_left = 1'b1;
                     r.clear_ack_right = 1'b1;
                  end
                  if (w.left_cmd && w.ack_left) r.clear_ack_left = 1'b1;
                  if (w.right_cmd && w.ack_right) r.clear_ack_right = 1'b1;
                  if (r.clear_ack_left || r.clear_ack_right)
                     state = (state == tibc_pkg::ST_ACT_ON) ? tibc_pkg::ST_ACK_ON
                                                            : tibc_pkg::ST_ACK_OFF;
               end
            end
            tibc_pkg::ST_ACK_ON, tibc_pkg::ST_ACK_OFF: begin
               ticks = ticks + 8'd1;
               if (switched_off(w)) begin
                  go_dark(w);
               end else if (ticks >= timeout) begin
                  if (w.hazard_cmd) hz_lit = !hz_lit;
                  if (w.left_cmd) left_lit = !left_lit;
                  if (w.right_cmd) right_lit = !right_lit;
                  ticks = '0;
                  state = (state == tibc_pkg::ST_ACK_ON) ? tibc_pkg::ST_ACT_OFF
                                                         : tibc_pkg::ST_ACT_ON;
               end
            end
            tibc_pkg::ST_FAULT: begin
               hz_lit = 1'b0;
               left_lit = 1'b0;
               right_lit = 1'b0;
               state = tibc_pkg::ST_HALTED;
            end
            default: begin
            end
         endcase
         r.lamp_hazard = hz_lit;
         r.lamp_left = left_lit;
         r.lamp_right = right_lit;
         r.state_code = state;
         r.halted = (state == tibc_pkg::ST_HALTED);
         due_reports.push_back(r);
      endfunction

      function void compare_field(string what, int want, int got);
         if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
         end
      endfunction

      function void check_report(tibc_pkg::rsp_type got);
         tibc_pkg::rsp_type want;
         if (due_reports.size() == 0) begin
            $display("%0t: report %h arrived with no tick pending", $time, got);
            mismatches++;
            return;
         end
         want = due_reports.pop_front();
         compare_field("lamp_hazard", want.lamp_hazard, got.lamp_hazard);
         compare_field("lamp_left", want.lamp_left, got.lamp_left);
         compare_field("lamp_right", want.lamp_right, got.lamp_right);
         compare_field("clear_ack_left", want.clear_ack_left, got.clear_ack_left);
         compare_field("clear_ack_right", want.clear_ack_right, got.clear_ack_right);
         compare_field("state_code", want.state_code, got.state_code);
         compare_field("halted", want.halted, got.halted);
      endfunction
   endclass

   blink_scoreboard sb = new();
   bit sender_gaps;
   bit receiver_stalls;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // Receiver: random runs of ready and, while stalls are enabled, of stall.
   initial begin
      int run_left;
      bit stalling;
      run_left = 0;
      stalling = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (run_left == 0) begin
            if (receiver_stalls && $urandom_range(0, 2) == 0) begin
               stalling = 1'b1;
               run_left = $urandom_range(1, 5);
            end else begin
               stalling = 1'b0;
               run_left = $urandom_range(1, 12);
            end
         end
         run_left--;
         rsp_ch.ready <= !stalling;
      end
   end

   always @(posedge clock) begin
      tibc_pkg::rsp_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.lamp_hazard = rsp_ch.lamp_hazard;
         got.lamp_left = rsp_ch.lamp_left;
         got.lamp_right = rsp_ch.lamp_right;
         got.clear_ack_left = rsp_ch.clear_ack_left;
         got.clear_ack_right = rsp_ch.clear_ack_right;
         got.state_code = rsp_ch.state_code;
         got.halted = rsp_ch.halted;
         sb.check_report(got);
      end
   end

   task automatic send_word(tibc_pkg::req_type w);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.hazard_cmd <= w.hazard_cmd;
      req_ch.left_cmd <= w.left_cmd;
      req_ch.right_cmd <= w.right_cmd;
      req_ch.ack_left <= w.ack_left;
      req_ch.ack_right <= w.ack_right;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_tick(w);
   endtask

   task automatic write_timeout(logic [tibc_pkg::TICK_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_timeout(value);
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Commands that turn off at least one lit lamp ({hazard, left, right}).
   function automatic logic [2:0] dark_cmds(logic [2:0] cmds, logic [2:0] lit,
                                            bit all_off);
      logic [1:0] idx;
      if (all_off) return 3'b000;
      if ((~cmds & lit) == 3'b000) begin
         do idx = 2'($urandom_range(0, 2)); while (!lit[idx]);
         cmds[idx] = 1'b0;
      end
      return cmds;
   endfunction

   // Picks the next tick so that the controller keeps blinking instead of
   // running into the acknowledge timeout, unless a fault is wanted.
   function automatic tibc_pkg::req_type pick_word(bit wind_down, bit fault_ok);
      logic [2:0] cmds;
      logic [1:0] acks;
      logic [2:0] lit;
      int nt;
      logic [1:0] idx;
      cmds = 3'($urandom_range(0, 7));
      acks = 2'($urandom_range(0, 3));
      lit = {sb.hz_lit, sb.left_lit, sb.right_lit};
      nt = (sb.ticks + 1) % 256;
      if (fault_ok) begin
         // Half of these hold the lamps and starve the acknowledge.
         if ($urandom_range(0, 1) == 0) begin
            cmds |= lit;
            acks = 2'b00;
         end
         return tibc_pkg::req_type'({cmds, acks});
      end
      case (sb.state)
         tibc_pkg::ST_OFF: begin
            if (wind_down || $urandom_range(0, 4) == 0) cmds = 3'b000;
         end
         tibc_pkg::ST_ACT_ON, tibc_pkg::ST_ACT_OFF: begin
            if (lit != 3'b000 &&
                (wind_down || nt >= sb.timeout || $urandom_range(0, 19) == 0)) begin
               cmds = dark_cmds(cmds, lit, wind_down);
            end else begin
               cmds |= lit;
               if (nt + 1 >= sb.timeout || $urandom_range(0, 2) == 0) begin
                  if (cmds == 3'b000) cmds[2'($urandom_range(0, 2))] = 1'b1;
                  do idx = 2'($urandom_range(0, 2)); while (!cmds[idx]);
                  if (idx == 2'd2) acks = 2'b11;
                  else acks[idx[0]] = 1'b1;
               end else begin
                  if (cmds[1]) acks[1] = 1'b0;
                  if (cmds[0]) acks[0] = 1'b0;
                  if (cmds[2] && acks == 2'b11) acks[1'($urandom_range(0, 1))] = 1'b0;
               end
            end
         end
         tibc_pkg::ST_ACK_ON, tibc_pkg::ST_ACK_OFF: begin
            if (lit != 3'b000 && (wind_down || $urandom_range(0, 39) == 0)) begin
               cmds = dark_cmds(cmds, lit, wind_down);
            end else begin
               cmds |= lit;
               // Light everything at the next blink so that it can be switched off.
               if (wind_down) cmds = 3'b111;
            end
         end
         default: begin
         end
      endcase
      return tibc_pkg::req_type'({cmds, acks});
   endfunction

   initial begin
      tibc_pkg::req_type opening[25];
      int plan_timeout[NUM_PHASES];
      int plan_words[NUM_PHASES];
      bit plan_idle[NUM_PHASES];
      int tmo;
      bit last_phase;

      // Words are {hazard_cmd, left_cmd, right_cmd, ack_left, ack_right}.
      opening = '{5'b11111, 5'b00000, 5'b10000, 5'b10010, 5'b10011,
                  5'b10000, 5'b10011, 5'b10000, 5'b10000, 5'b00011,
                  5'b01010, 5'b01111, 5'b01000, 5'b01100, 5'b01001,
                  5'b00100, 5'b00101, 5'b00000, 5'b11100, 5'b11111,
                  5'b11100, 5'b11100, 5'b00000, 5'b10011, 5'b00000};
      plan_timeout = '{10, 1, 255, 0, 2, -1, 5, 4};
      plan_words = '{200, 60, 300, 60, 150, 150, 150, 80};
      plan_idle = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.hazard_cmd <= 1'b0;
      req_ch.left_cmd <= 1'b0;
      req_ch.right_cmd <= 1'b0;
      req_ch.ack_left <= 1'b0;
      req_ch.ack_right <= 1'b0;
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A short blink period lets the opening sequence reach every state
      // short of the error.
      write_timeout(8'd3);
      foreach (opening[i]) send_word(opening[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         last_phase = (p == NUM_PHASES - 1);
         // Park the controller in its off state before the timeout changes.
         while (sb.state != tibc_pkg::ST_OFF) send_word(pick_word(1'b1, 1'b0));
         req_ch.valid <= 1'b0;
         wait_drained();
         tmo = (plan_timeout[p] < 0) ? $urandom_range(2, 40) : plan_timeout[p];
         write_timeout(tmo[tibc_pkg::TICK_W-1:0]);
         sender_gaps = plan_idle[p];
         receiver_stalls = plan_idle[p];
         for (int n = 0; n < plan_words[p]; n++)
            send_word(pick_word(1'b0, last_phase && n >= 20));
      end
      req_ch.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tibc_pkg.sv
rtl/tibc_ifs.sv
rtl/tibc_core.sv
rtl/turn_indicator_blink_controller.sv
tb/tb_turn_indicator_blink_controller.sv
